// File: hdl/sparse_lower_level_set_unit_assert.svh
// Assertion macros for the sparse lower level-set unit checker.
// No dependencies.
`ifndef SPARSE_LOWER_LEVEL_SET_UNIT_ASSERT_SVH
`define SPARSE_LOWER_LEVEL_SET_UNIT_ASSERT_SVH
// Implication checked every cycle outside reset.
`define SLLS_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define SLLS_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: hdl/slls_pkg.sv
// Package for the sparse lower level-set unit: payload types, codes and sizes.
// No dependencies.
`default_nettype none
package slls_pkg;
  localparam int MAX_NODES    = 1024;
  localparam int MAX_NONZEROS = 8192;

  localparam logic [1:0] MODE_LOAD_PTR = 2'd0;
  localparam logic [1:0] MODE_LOAD_ROW = 2'd1;
  localparam logic [1:0] MODE_COMPUTE  = 2'd2;
  localparam logic [1:0] MODE_READ     = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_PROG  = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [12:0] position;
    logic [13:0] load_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] level_count;
    logic [9:0]  node;
    logic [9:0]  level;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_NNZ, ST_CNT, ST_SCAN, ST_PTR0, ST_PTR1, ST_EDGE,
    ST_NEXTQ, ST_DONE, ST_READ
  } state_t;
endpackage
`default_nettype wire

// File: hdl/sparse_lower_level_set_unit.sv
// Top level of the sparse lower level-set unit: sequencer plus memories.
// Depends on slls_pkg.
//
// Usage: drive cmd with start high while busy is low; that edge accepts the
// transaction. Column pointer loads (mode 0) and row index loads (mode 1)
// write one word and produce no result; busy stays low, so loads may be
// issued every cycle. A read (mode 3) holds busy through states NNZ and
// READ: the order memories are read into registers in NNZ, then result and
// done are registered in READ; done pulses for exactly one cycle. A compute
// (mode 2) holds busy high for its whole run: it clears the degree and mark
// memories, counts in-degrees, then per pass scans the degree memory and,
// for each node placed, fetches its column bounds, walks one column entry
// per cycle and drains the edge pipeline. Each decrement is a
// read-modify-write through the edge, degree and write stages; hits on one
// row from the pending write or the write of the last edge are forwarded.
// The receiver cannot stall: done is a one-cycle strobe, and result holds
// until the next compute or read completes. cfg_ready is high whenever
// busy is low.
// Reset clears the sequencer, level count and order length; the matrix and
// order memories are undefined until written, degree/mark memories are
// rebuilt at each compute.
`default_nettype none
module sparse_lower_level_set_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire slls_pkg::cmd_t  cmd,
  output logic                 busy,
  output logic                 done,
  output slls_pkg::result_t    result,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [10:0]     cfg_data
);
  import slls_pkg::*;
  localparam int NW = $clog2(MAX_NODES);
  localparam int EW = $clog2(MAX_NONZEROS);
  localparam int PW = $clog2(MAX_NONZEROS + 1);
  localparam int CW = $clog2(MAX_NODES + 1);

  // memories
  logic [PW-1:0] ptr_mem [MAX_NODES+1];
  logic [NW:0]   row_mem [MAX_NONZEROS];
  logic [10:0]   deg_mem [MAX_NODES];
  logic          vis_mem [MAX_NODES];
  logic [NW-1:0] ord_node [MAX_NODES];
  logic [9:0]    ord_lvl  [MAX_NODES];

  state_t state, state_next;
  logic [10:0] node_count;
  logic [CW-1:0] n;
  logic [PW-1:0] nnz;
  logic [EW:0]   k;        // edge walker
  logic [PW-1:0] hi;
  logic [CW-1:0] i;        // node walker
  logic [CW-1:0] placed, first, q;
  logic [10:0]   lvl;
  logic [10:0]   levels_found;
  logic [CW-1:0] order_valid;
  logic [NW-1:0] cur_c;

  // read-data registers
  logic [PW-1:0] ptr_rd;
  logic [NW:0]   row_rd;
  logic [10:0]   deg_rd;
  logic          vis_rd;
  logic [NW-1:0] on_rd;
  logic [9:0]    ol_rd;

  // pipelined edge stage: row read issued last cycle
  logic          e_v;
  logic          e_mode;   // 1 count, 0 decrement
  logic          w_v;
  logic [NW-1:0] w_addr;
  logic [10:0]   w_data;
  // write that landed at the last edge, missed by the read at that edge
  logic          w2_v;
  logic [NW-1:0] w2_addr;
  logic [10:0]   w2_data;

  logic [12:0] rd_pos;
  logic        rd_ok;

  always_comb begin
    n = CW'(MAX_NODES);
    if (node_count == 11'd0) n = CW'(1);
    else if ({21'd0, node_count} < MAX_NODES) n = node_count[CW-1:0];
  end

  assign busy = (state != ST_IDLE);
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) node_count <= 11'd1;
    else if (cfg_valid && cfg_ready) node_count <= cfg_data;
  end

  // loads
  always_ff @(posedge clk) begin
    if (start && !busy && cmd.mode == MODE_LOAD_PTR && {19'd0, cmd.position} <= MAX_NODES)
      ptr_mem[cmd.position[CW-1:0]] <= (cmd.load_value > 14'(MAX_NONZEROS))
                                        ? PW'(MAX_NONZEROS) : cmd.load_value[PW-1:0];
    if (start && !busy && cmd.mode == MODE_LOAD_ROW && {19'd0, cmd.position} < MAX_NONZEROS)
      row_mem[cmd.position[EW-1:0]] <= (cmd.load_value >= 14'(MAX_NODES))
                                        ? (NW+1)'(MAX_NODES) : cmd.load_value[NW:0];
  end

  // memory read addresses (combinational), registered data
  logic [CW-1:0] ptr_ra;
  logic [EW-1:0] row_ra;
  logic [NW-1:0] deg_ra;
  always_comb begin
    ptr_ra = n;
    if (state == ST_PTR0) ptr_ra = CW'(on_rd);
    else if (state == ST_PTR1) ptr_ra = CW'(cur_c) + CW'(1);
    row_ra = k[EW-1:0];
    deg_ra = i[NW-1:0];
    if (state == ST_CNT || state == ST_EDGE) deg_ra = row_rd[NW-1:0];
  end

  always_ff @(posedge clk) begin
    ptr_rd <= ptr_mem[ptr_ra];
    row_rd <= row_mem[row_ra];
    deg_rd <= deg_mem[deg_ra];
    vis_rd <= vis_mem[deg_ra];
    on_rd  <= ord_node[(state == ST_NEXTQ || state == ST_SCAN) ? q[NW-1:0] : rd_pos[NW-1:0]];
    ol_rd  <= ord_lvl[rd_pos[NW-1:0]];
  end

  // row address valid for edge stage
  logic row_take;
  assign row_take = e_v && row_rd < (NW+1)'(n) && (e_mode || row_rd[NW-1:0] != cur_c);
  // row_rd is registered from the row read, and deg_rd from the deg read addressed by row_rd.
  // Keep one more stage for the degree.
  logic          d_v, d_mode;
  logic [NW-1:0] d_addr;
  logic [10:0]   d_cur;
  assign d_cur = (w_v && w_addr == d_addr) ? w_data
               : (w2_v && w2_addr == d_addr) ? w2_data : deg_rd;

  // scan pipeline: address i, data registered into deg_rd/vis_rd
  logic          s_v;
  logic [NW-1:0] s_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      levels_found <= '0;
      order_valid <= '0;
      done <= 1'b0;
      e_v <= 1'b0; d_v <= 1'b0; w_v <= 1'b0; s_v <= 1'b0; w2_v <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      w_v <= 1'b0;
      e_v <= 1'b0;
      s_v <= 1'b0;
      w2_v <= w_v;
      w2_addr <= w_addr;
      w2_data <= w_data;
      d_v <= e_v && row_take;
      d_mode <= e_mode;
      d_addr <= row_rd[NW-1:0];
      if (d_v) begin
        w_v <= 1'b1;
        w_addr <= d_addr;
        if (d_mode) w_data <= (d_cur < 11'd2047) ? d_cur + 11'd1 : d_cur;
        else w_data <= (d_cur != 11'd0) ? d_cur - 11'd1 : d_cur;
      end
      case (state)
        ST_IDLE: begin
          if (start && cmd.mode == MODE_COMPUTE) begin
            i <= '0; order_valid <= '0; levels_found <= '0;
          end else if (start && cmd.mode == MODE_READ) begin
            rd_pos <= cmd.position;
            rd_ok <= {{(13-CW){1'b0}}, order_valid} > cmd.position;
          end
        end
        ST_CLR: begin
          i <= i + CW'(1);
          if (i == n - CW'(1)) begin
            nnz <= ptr_rd; k <= '0;
          end
        end
        ST_NNZ: begin k <= '0; end
        ST_CNT: begin
          if ({1'b0, k} < (EW+2)'(nnz)) begin
            e_v <= 1'b1; e_mode <= 1'b1; k <= k + (EW+1)'(1);
          end
          if (state_next == ST_SCAN) begin
            i <= '0; placed <= '0; lvl <= '0; first <= '0;
          end
        end
        ST_SCAN: begin
          if (i < n) begin s_v <= 1'b1; s_addr <= i[NW-1:0]; i <= i + CW'(1); end
          if (s_v && !vis_rd && deg_rd == 11'd1) begin
            placed <= placed + CW'(1);
          end
          if (state_next == ST_NEXTQ) q <= first;
        end
        ST_NEXTQ: ;
        ST_PTR0: begin
          cur_c <= on_rd;
        end
        ST_PTR1: begin
          k <= (EW+1)'((ptr_rd > nnz) ? nnz : ptr_rd);
        end
        ST_EDGE: begin
          if ({1'b0, k} < (EW+2)'(hi)) begin
            e_v <= 1'b1; e_mode <= 1'b0; k <= k + (EW+1)'(1);
          end
          if (state_next == ST_NEXTQ) q <= q + CW'(1);
          if (state_next == ST_SCAN) begin
            i <= '0; first <= placed; lvl <= lvl + 11'd1;
          end
          if (state_next == ST_DONE) lvl <= lvl + 11'd1;
        end
        ST_DONE: begin
          done <= 1'b1;
          if (placed == n) begin
            levels_found <= lvl; order_valid <= placed;
            result <= '{STATUS_OK, lvl, 10'd0, 10'd0};
          end else result <= '{STATUS_NO_PROG, 11'd0, 10'd0, 10'd0};
        end
        ST_READ: begin
          done <= 1'b1;
          if (rd_ok) result <= '{STATUS_OK, levels_found, 10'(on_rd), ol_rd};
          else result <= '{STATUS_RANGE, levels_found, 10'd0, 10'd0};
        end
        default: ;
      endcase
    end
  end

  // hi capture: PTR1 reads ptr[c+1]; data arrives next cycle (first EDGE)
  logic hi_load;
  always_ff @(posedge clk) begin
    if (rst) hi_load <= 1'b0;
    else hi_load <= (state == ST_PTR1);
  end
  logic [PW-1:0] hi_eff;
  assign hi_eff = hi_load ? ((ptr_rd > nnz) ? nnz : ptr_rd) : hi;
  always_ff @(posedge clk) begin
    if (state == ST_PTR0) hi <= '0;
    else if (hi_load) hi <= hi_eff;
  end

  // degree and mark writes
  logic sel;
  assign sel = (state == ST_SCAN) && s_v && !vis_rd && deg_rd == 11'd1;
  always_ff @(posedge clk) begin
    if (state == ST_CLR) begin
      deg_mem[i[NW-1:0]] <= '0;
      vis_mem[i[NW-1:0]] <= 1'b0;
    end else if (w_v) deg_mem[w_addr] <= w_data;
    else if (sel) vis_mem[s_addr] <= 1'b1;
    if (sel) begin
      ord_node[placed[NW-1:0]] <= s_addr;
      ord_lvl[placed[NW-1:0]] <= lvl[9:0];
    end
  end

  logic pipe_idle;
  assign pipe_idle = !e_v && !d_v && !w_v;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) begin
        if (cmd.mode == MODE_COMPUTE) state_next = ST_CLR;
        else if (cmd.mode == MODE_READ) state_next = ST_NNZ;
      end
      ST_CLR: if (i == n - CW'(1)) state_next = ST_CNT;
      ST_NNZ: state_next = ST_READ;
      ST_CNT: if ({1'b0, k} >= (EW+2)'(nnz) && pipe_idle) state_next = ST_SCAN;
      ST_SCAN: if (i >= n && !s_v) state_next = (placed == first) ? ST_DONE : ST_NEXTQ;
      ST_NEXTQ: state_next = ST_PTR0;
      ST_PTR0: state_next = ST_PTR1;
      ST_PTR1: state_next = ST_EDGE;
      ST_EDGE: if (!hi_load && {1'b0, k} >= (EW+2)'(hi_eff) && pipe_idle) begin
        if (q + CW'(1) < placed) state_next = ST_NEXTQ;
        else if (placed == n) state_next = ST_DONE;
        else state_next = ST_SCAN;
      end
      ST_DONE: state_next = ST_IDLE;
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/slls_checker.sv
// Port checker for the sparse lower level-set unit, bound to the top level.
// Depends on slls_pkg and sparse_lower_level_set_unit_assert.svh.
`default_nettype none
`include "sparse_lower_level_set_unit_assert.svh"
module slls_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire logic              cfg_ready,
  input wire slls_pkg::cmd_t    cmd,
  input wire slls_pkg::result_t result
);
  import slls_pkg::*;
  `SLLS_ASSERT_IMPL(cfg_when_idle, clk, rst, cfg_ready, !busy)
  `SLLS_ASSERT_NEXT(read_goes_busy, clk, rst,
    start && !busy && cmd.mode == MODE_READ, busy)
  `SLLS_ASSERT_NEXT(load_stays_idle, clk, rst,
    start && !busy && (cmd.mode == MODE_LOAD_PTR || cmd.mode == MODE_LOAD_ROW), !busy)
  `SLLS_ASSERT_IMPL(status_legal, clk, rst, done, result.status != 2'd3)
endmodule
bind sparse_lower_level_set_unit slls_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .cfg_ready(cfg_ready), .cmd(cmd), .result(result)
);
`default_nettype wire
